### rtl/bitmap_frame_allocator_defines.svh
// Assertion macros for the frame allocator checker.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// Property checked on every rising edge of clock, off while reset is high.
`define BFA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every rising edge of clock, also during reset.
`define BFA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/bfa_pkg.sv
// Shared constants, codes and types of the bitmap frame allocator.
package bfa_pkg;

   // Sizes of the frame map.
   localparam int MAX_FRAMES = 4096;
   localparam int WORD_BITS  = 32;
   localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int ADDR_W     = $clog2(MAP_WORDS);
   localparam int FRAME_W    = ADDR_W + BIT_W;
   localparam int WCNT_W     = ADDR_W + 1;
   localparam int COUNT_W    = 13;
   localparam int STATUS_W   = 3;

   // Request opcodes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_ALLOCATED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MAPPED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_FREE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FREED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd4;

   // Access to the map memory for one cycle.
   typedef struct packed {
      logic                 rd_en;
      logic [ADDR_W-1:0]    rd_addr;
      logic                 wr_en;
      logic [ADDR_W-1:0]    wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } map_req_type;

endpackage

### rtl/bfa_map.sv
// Used/free bitmap memory with one read and one write port and per-word valid bits.
module bfa_map (
   input  logic                         clock,
   input  logic                         reset,
   input  bfa_pkg::map_req_type         map_req,
   output logic [bfa_pkg::WORD_BITS-1:0] rd_data
);
   import bfa_pkg::*;

   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] valid_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;

   // Word storage: written words become valid, read data is registered.
   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         map_mem[map_req.wr_addr] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_data_ff <= map_mem[map_req.rd_addr];
      end
   end

   // A word never written since reset reads as all free.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (map_req.wr_en) begin
            valid_ff[map_req.wr_addr] <= 1'b1;
         end
         if (map_req.rd_en) begin
            rd_valid_ff <= valid_ff[map_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

### rtl/bfa_find.sv
// Lowest clear bit of one bitmap word.
module bfa_find (
   input  logic [bfa_pkg::WORD_BITS-1:0] word,
   output logic                          found,
   output logic [bfa_pkg::BIT_W-1:0]     bit_idx,
   output logic [bfa_pkg::WORD_BITS-1:0] bit_mask
);
   import bfa_pkg::*;

   logic [WORD_BITS-1:0] free_bits;

   // Isolate the lowest set bit of the inverted word.
   assign free_bits = ~word;
   assign bit_mask  = free_bits & (~free_bits + WORD_BITS'(1));
   assign found     = |free_bits;

   // Encode the one-hot mask into a bit index.
   always_comb begin
      bit_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (bit_mask[i]) begin
            bit_idx = bit_idx | BIT_W'(i);
         end
      end
   end

endmodule

### rtl/bitmap_frame_allocator.sv
// Top level of the bitmap page frame allocator: control sequencer and registers.
//
//  Channel | Direction | Handshake           | Payload
//  req     | in        | req_valid/req_ready | opcode, entry_frame, want_writable, want_privileged
//  rsp     | out       | rsp_valid/rsp_ready | status, frame_number, present, writable, privileged
//  csr     | in        | csr_valid/csr_ready | frames_in_use
//
// An allocate scans the map word by word, at most 128 words, and the single map read port
// delivers one word per cycle. It passes from the idle state through the scan and done
// states; a free passes through the free and done states, an already mapped, ignored or
// empty-range item straight to the done state. A finished result waits while the output
// register still holds an earlier one; the next request is taken once it has moved there.
// After reset all frames are free at once (per-word valid bits, no clearing pass).
module bitmap_frame_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_opcode,
   input  logic [bfa_pkg::FRAME_W-1:0]   req_entry_frame,
   input  logic                          req_want_writable,
   input  logic                          req_want_privileged,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bfa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bfa_pkg::FRAME_W-1:0]   rsp_frame_number,
   output logic                          rsp_present,
   output logic                          rsp_writable,
   output logic                          rsp_privileged,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bfa_pkg::COUNT_W-1:0]   csr_frames_in_use
);
   import bfa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_FREE = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     frames_ff;
   logic [WCNT_W-1:0]      words_ff, words_in, cfg_words;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [BIT_W-1:0]       bit_ff, bit_in;
   logic                   rw_ff, rw_in;
   logic                   priv_ff, priv_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic [FRAME_W-1:0]     res_frame_ff, res_frame_in;
   logic                   res_present_ff, res_present_in;
   logic                   res_wr_ff, res_wr_in;
   logic                   res_pv_ff, res_pv_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [FRAME_W-1:0]     rsp_frame_ff;
   logic                   rsp_present_ff, rsp_wr_ff, rsp_pv_ff;
   logic                   rsp_load;
   map_req_type            map_req;
   logic [WORD_BITS-1:0]   rd_data;
   logic                   free_found;
   logic [BIT_W-1:0]       free_idx;
   logic [WORD_BITS-1:0]   free_mask;
   logic [WCNT_W-1:0]      next_word;

   bfa_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .rd_data (rd_data)
   );

   bfa_find u_find (
      .word     (rd_data),
      .found    (free_found),
      .bit_idx  (free_idx),
      .bit_mask (free_mask)
   );

   // Configuration register; a count above the map size searches the whole map.
   assign csr_ready = 1'b1;
   assign cfg_words = (frames_ff > COUNT_W'(MAX_FRAMES)) ? WCNT_W'(MAP_WORDS)
                                                         : WCNT_W'(frames_ff >> BIT_W);

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= COUNT_W'(MAX_FRAMES);
      end else if (csr_valid && csr_ready) begin
         frames_ff <= csr_frames_in_use;
      end
   end

   assign next_word = WCNT_W'(addr_ff) + WCNT_W'(1);

   // Sequencer: accept, scan or read-modify-write the map, then hand off the result.
   always_comb begin
      state_in       = state_ff;
      words_in       = words_ff;
      addr_in        = addr_ff;
      bit_in         = bit_ff;
      rw_in          = rw_ff;
      priv_in        = priv_ff;
      res_status_in  = res_status_ff;
      res_frame_in   = res_frame_ff;
      res_present_in = res_present_ff;
      res_wr_in      = res_wr_ff;
      res_pv_in      = res_pv_ff;
      map_req        = '0;
      req_ready      = 1'b0;
      rsp_load       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready      = 1'b1;
            res_frame_in   = '0;
            res_present_in = 1'b0;
            res_wr_in      = 1'b0;
            res_pv_in      = 1'b0;
            if (req_valid) begin
               rw_in    = req_want_writable;
               priv_in  = req_want_privileged;
               words_in = cfg_words;
               if (req_opcode == OP_ALLOC) begin
                  if (req_entry_frame != '0) begin
                     res_status_in = ST_MAPPED;
                     res_frame_in  = req_entry_frame;
                     state_in      = S_DONE;
                  end else if (cfg_words == '0) begin
                     res_status_in = ST_NO_FREE;
                     state_in      = S_DONE;
                  end else begin
                     map_req.rd_en   = 1'b1;
                     map_req.rd_addr = '0;
                     addr_in         = '0;
                     state_in        = S_SCAN;
                  end
               end else begin
                  if (req_entry_frame == '0) begin
                     res_status_in = ST_IGNORED;
                     state_in      = S_DONE;
                  end else begin
                     map_req.rd_en   = 1'b1;
                     map_req.rd_addr = req_entry_frame[FRAME_W-1:BIT_W];
                     addr_in         = req_entry_frame[FRAME_W-1:BIT_W];
                     bit_in          = req_entry_frame[BIT_W-1:0];
                     state_in        = S_FREE;
                  end
               end
            end
         end
         S_SCAN: begin
            // The word at addr_ff is on rd_data; the next read is issued ahead.
            if (free_found) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = addr_ff;
               map_req.wr_data = rd_data | free_mask;
               res_status_in   = ST_ALLOCATED;
               res_frame_in    = {addr_ff, free_idx};
               res_present_in  = 1'b1;
               res_wr_in       = rw_ff;
               res_pv_in       = priv_ff;
               state_in        = S_DONE;
            end else if (next_word == words_ff) begin
               res_status_in = ST_NO_FREE;
               state_in      = S_DONE;
            end else begin
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = next_word[ADDR_W-1:0];
               addr_in         = next_word[ADDR_W-1:0];
            end
         end
         S_FREE: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = addr_ff;
            map_req.wr_data = rd_data & ~(WORD_BITS'(1) << bit_ff);
            res_status_in   = ST_FREED;
            state_in        = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: holds a result until its transfer completes.
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff       <= words_in;
      addr_ff        <= addr_in;
      bit_ff         <= bit_in;
      rw_ff          <= rw_in;
      priv_ff        <= priv_in;
      res_status_ff  <= res_status_in;
      res_frame_ff   <= res_frame_in;
      res_present_ff <= res_present_in;
      res_wr_ff      <= res_wr_in;
      res_pv_ff      <= res_pv_in;
      if (rsp_load) begin
         rsp_status_ff  <= res_status_ff;
         rsp_frame_ff   <= res_frame_ff;
         rsp_present_ff <= res_present_ff;
         rsp_wr_ff      <= res_wr_ff;
         rsp_pv_ff      <= res_pv_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_number = rsp_frame_ff;
   assign rsp_present      = rsp_present_ff;
   assign rsp_writable     = rsp_wr_ff;
   assign rsp_privileged   = rsp_pv_ff;

endmodule

### rtl/bfa_checker.sv
// Port-level assertions for the bitmap frame allocator and their bind.
`include "bitmap_frame_allocator_defines.svh"

module bfa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bfa_pkg::STATUS_W-1:0]  rsp_status,
   input logic [bfa_pkg::FRAME_W-1:0]   rsp_frame_number,
   input logic                          rsp_present,
   input logic                          rsp_writable,
   input logic                          rsp_privileged
);
   import bfa_pkg::*;

   logic                          rsp_stall;
   logic [STATUS_W+FRAME_W+2:0]   rsp_payload;
   logic                          page_bits;
   logic                          no_frame;

   // Shorthands for the result channel.
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_status, rsp_frame_number, rsp_present, rsp_writable,
                         rsp_privileged};
   assign page_bits   = rsp_present || rsp_writable || rsp_privileged;
   assign no_frame    = (rsp_status == ST_NO_FREE) || (rsp_status == ST_FREED)
                        || (rsp_status == ST_IGNORED);

   // A stalled result transfer keeps its payload.
   `BFA_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_payload), "rsp changed in stall")

   // Only an allocation sets the page entry bits.
   `BFA_ASSERT(a_bits_alloc_only, rsp_valid && rsp_status != ST_ALLOCATED |-> !page_bits, "bits set")

   // Results that hold no frame report frame zero.
   `BFA_ASSERT(a_no_frame, rsp_valid && no_frame |-> rsp_frame_number == '0, "frame on empty result")

   // No result is offered in the cycle after a reset cycle.
   `BFA_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "rsp_valid high after reset")

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);
